@@ design/tbo_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbo_pkg
// shared constants for the triangle / box overlap test
// ----------------------------------------------------------------------------
package tbo_pkg;

  localparam int unsigned DepthLevelsDef = 8;
  localparam int unsigned CoordBitsDef   = 20;
  localparam int unsigned WordBits       = 60;
  localparam int unsigned DepthBits      = 3;
  localparam int unsigned CfgIdxBits     = 3;

endpackage

@@ design/tbo_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbo_core
// pipelined 13-axis separating axis test on unpacked coordinates
// ----------------------------------------------------------------------------
module tbo_core #(
  parameter int unsigned CoordBits = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [2:0][2:0][CoordBits-1:0] v_i,
  input  logic signed [2:0][CoordBits-1:0]    c_i,
  input  logic [2:0][CoordBits-1:0]           a_i,
  output logic                                valid_o,
  output logic                                overlap_o
);
  import tbo_pkg::*;

  localparam int unsigned DB = CoordBits + 2;   // differences
  localparam int unsigned NB = 2 * DB + 1;      // normal components
  localparam int unsigned PB = NB + DB + 1;     // normal times difference
  localparam int unsigned SB = PB + 3;          // three-term sums
  localparam int unsigned XB = 2 * DB + 2;      // cross axis products
  localparam int unsigned RB = DB + CoordBits + 2;

  // stage 1: differences
  logic                        s1_vld_q;
  logic signed [2:0][DB-1:0]   d_q, e0_q, e1_q, e2_q;
  logic [2:0][CoordBits-1:0]   a1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else         s1_vld_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      d_q[k]  <= DB'($signed(v_i[0][k])) - DB'($signed(c_i[k]));
      e0_q[k] <= DB'($signed(v_i[1][k])) - DB'($signed(v_i[0][k]));
      e1_q[k] <= DB'($signed(v_i[2][k])) - DB'($signed(v_i[0][k]));
      e2_q[k] <= DB'($signed(v_i[2][k])) - DB'($signed(v_i[1][k]));
    end
    a1_q <= a_i;
  end

  // stage 2: normal products, box axis test, cross axis products
  logic                        s2_vld_q, boxsep_q;
  logic signed [2:0][NB-1:0]   nl_q, nr_q;
  logic signed [2:0][2:0][XB-1:0] xl_q, xr_q;
  logic [2:0][2:0][RB-1:0]     rl_q, rr_q;
  logic signed [2:0][DB-1:0]   d2_q;
  logic [2:0][CoordBits-1:0]   a2_q;
  logic                        boxsep_d;

  function automatic logic signed [DB-1:0] pick(input logic signed [2:0][DB-1:0] x0,
      input logic signed [2:0][DB-1:0] x1, input logic signed [2:0][DB-1:0] x2,
      input int j, input int k);
    logic signed [DB-1:0] r;
    case (j)
      0:       r = x0[k];
      1:       r = x1[k];
      default: r = x2[k];
    endcase
    return r;
  endfunction

  function automatic logic [DB-1:0] mag(input logic signed [DB-1:0] x);
    return x[DB-1] ? DB'(-x) : DB'(x);
  endfunction

  function automatic logic [NB-1:0] nabs(input logic signed [NB-1:0] x);
    return x[NB-1] ? NB'(-x) : NB'(x);
  endfunction

  always_comb begin
    logic signed [DB:0] p1, p2, mn, mx, ra;
    boxsep_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      p1 = (DB+1)'($signed(d_q[k])) + (DB+1)'($signed(e0_q[k]));
      p2 = (DB+1)'($signed(d_q[k])) + (DB+1)'($signed(e1_q[k]));
      mn = (DB+1)'($signed(d_q[k])); mx = mn;
      if (p1 < mn) mn = p1;
      if (p2 < mn) mn = p2;
      if (p1 > mx) mx = p1;
      if (p2 > mx) mx = p2;
      ra = (DB+1)'($signed({1'b0, a1_q[k]}));
      if (mn > ra || mx < -ra) boxsep_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else         s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    boxsep_q <= boxsep_d;
    d2_q     <= d_q;
    a2_q     <= a1_q;
    for (int i = 0; i < 3; i++) begin
      nl_q[i] <= NB'($signed(e0_q[(i+1)%3])) * NB'($signed(e1_q[(i+2)%3]));
      nr_q[i] <= NB'($signed(e0_q[(i+2)%3])) * NB'($signed(e1_q[(i+1)%3]));
      for (int j = 0; j < 3; j++) begin
        xl_q[i][j] <= XB'(pick(e0_q, e1_q, e2_q, j, (i+1)%3)) *
                      XB'($signed(d_q[(i+2)%3]));
        xr_q[i][j] <= XB'(pick(e0_q, e1_q, e2_q, j, (i+2)%3)) *
                      XB'($signed(d_q[(i+1)%3]));
        rl_q[i][j] <= RB'(a1_q[(i+1)%3]) * RB'(mag(pick(e0_q, e1_q, e2_q, j, (i+2)%3)));
        rr_q[i][j] <= RB'(a1_q[(i+2)%3]) * RB'(mag(pick(e0_q, e1_q, e2_q, j, (i+1)%3)));
      end
    end
  end

  // stage 3: normal, cross axis test, radius sums
  logic                        s3_vld_q, sep3_q, sep3_d;
  logic signed [2:0][NB-1:0]   n3_q;
  logic signed [2:0][DB-1:0]   d3_q;
  logic [2:0][CoordBits-1:0]   a3_q;
  logic signed [2:0][NB-1:0]   n_w;

  always_comb begin
    logic signed [XB:0]  p0, q, mn, mx, rad;
    sep3_d = boxsep_q;
    for (int i = 0; i < 3; i++) n_w[i] = nl_q[i] - nr_q[i];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p0 = (XB+1)'($signed(xl_q[i][j])) - (XB+1)'($signed(xr_q[i][j]));
        q  = (j == 0) ? p0 + (XB+1)'($signed(n_w[i])) : p0 - (XB+1)'($signed(n_w[i]));
        rad = (XB+1)'(rl_q[i][j]) + (XB+1)'(rr_q[i][j]);
        mn = (p0 < q) ? p0 : q;
        mx = (p0 > q) ? p0 : q;
        if (mn > rad || mx < -rad) sep3_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else         s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    sep3_q <= sep3_d;
    n3_q   <= n_w;
    d3_q   <= d2_q;
    a3_q   <= a2_q;
  end

  // stage 4: normal axis products
  logic                        s4_vld_q, sep4_q;
  logic signed [2:0][PB-1:0]   pn_q, rn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_vld_q <= 1'b0;
    else         s4_vld_q <= s3_vld_q;
  end

  always_ff @(posedge clk_i) begin
    sep4_q <= sep3_q;
    for (int i = 0; i < 3; i++) begin
      pn_q[i] <= PB'($signed(n3_q[i])) * PB'($signed(d3_q[i]));
      rn_q[i] <= PB'($signed({1'b0, a3_q[i]})) * PB'($signed({1'b0, nabs(n3_q[i])}));
    end
  end

  // stage 5: final compare
  logic              s5_vld_q, ovl_q;
  logic signed [SB-1:0] p_w, r_w;

  assign p_w = SB'($signed(pn_q[0])) + SB'($signed(pn_q[1])) + SB'($signed(pn_q[2]));
  assign r_w = SB'($signed(rn_q[0])) + SB'($signed(rn_q[1])) + SB'($signed(rn_q[2]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
      ovl_q    <= 1'b0;
    end else begin
      s5_vld_q <= s4_vld_q;
      ovl_q    <= s4_vld_q && !(sep4_q || p_w > r_w || -r_w > p_w);
    end
  end

  assign valid_o   = s5_vld_q;
  assign overlap_o = ovl_q;

endmodule

@@ design/triangle_box_overlap_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_box_overlap_test
// triangle versus axis-aligned box overlap by separating axis test
// ----------------------------------------------------------------------------
// usage:
//   input: drive vertices, box center and node depth with start_i; the
//   transfer happens at a clock edge with start_i high and busy_o low.
//   busy_o is always low: a new pair can enter every cycle.
//   output: done_o pulses for one cycle with overlaps_o once the input has
//   passed the core pipeline; results come back in input order.
//   config: cfg_valid_i/cfg_ready_o write channel, cfg_index_i selects the
//   depth level, cfg_data_i holds three packed half extents (x lowest).
//   indexes at or beyond the level count are dropped. write only when idle.
//   the core has five register stages (differences, products, cross axis
//   compare, normal products, final compare).
//   reset clears all half extents to zero and empties the pipeline.
//   the receiver cannot stall; results are never held.
//   depths at or beyond the level count use the last level.
// ----------------------------------------------------------------------------
module triangle_box_overlap_test #(
  parameter int unsigned DepthLevels = tbo_pkg::DepthLevelsDef,
  parameter int unsigned CoordBits   = tbo_pkg::CoordBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [tbo_pkg::WordBits-1:0]    vertex_first_i,
  input  logic [tbo_pkg::WordBits-1:0]    vertex_second_i,
  input  logic [tbo_pkg::WordBits-1:0]    vertex_third_i,
  input  logic [tbo_pkg::WordBits-1:0]    box_center_i,
  input  logic [tbo_pkg::DepthBits-1:0]   node_depth_i,
  output logic                            done_o,
  output logic                            overlaps_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tbo_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [tbo_pkg::WordBits-1:0]    cfg_data_i
);
  import tbo_pkg::*;

  localparam int unsigned LvlBits = (DepthLevels > 1) ? $clog2(DepthLevels) : 1;

  // half extents per level
  logic [DepthLevels-1:0][3*CoordBits-1:0] ext_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q <= '0;
    end else if (cfg_valid_i && 32'(cfg_index_i) < DepthLevels) begin
      ext_q[LvlBits'(cfg_index_i)] <= cfg_data_i[3*CoordBits-1:0];
    end
  end

  // level select, clamped to the last level
  logic [LvlBits-1:0] lvl;
  assign lvl = (32'(node_depth_i) >= DepthLevels) ? LvlBits'(DepthLevels - 1)
                                                  : LvlBits'(node_depth_i);

  logic signed [2:0][2:0][CoordBits-1:0] v;
  logic signed [2:0][CoordBits-1:0]      c;
  logic [2:0][CoordBits-1:0]             a;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v[0][k] = vertex_first_i[k*CoordBits +: CoordBits];
      v[1][k] = vertex_second_i[k*CoordBits +: CoordBits];
      v[2][k] = vertex_third_i[k*CoordBits +: CoordBits];
      c[k]    = box_center_i[k*CoordBits +: CoordBits];
      a[k]    = ext_q[lvl][k*CoordBits +: CoordBits];
    end
  end

  tbo_core #(.CoordBits(CoordBits)) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i && !busy_o),
    .v_i      (v),
    .c_i      (c),
    .a_i      (a),
    .valid_o  (done_o),
    .overlap_o(overlaps_o)
  );

`ifndef SYNTHESIS
  // each result follows an accepted pair and each accepted pair gives a result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 5)) else $error("result without input");
  a_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##5 done_o) else $error("lost result");
  // the overlap flag is low between results
  a_ovl_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !overlaps_o) else $error("stale overlap flag");
`endif

endmodule
